/* rtl/tdn_pkg.sv */
// ----------------------------------------------------------------------------
// Ternary digit neighbor generator package
// Widths, powers of three and shared types for the decoder cells and the
// result emitter.
// ----------------------------------------------------------------------------
package tdn_pkg;

   localparam int IDX_W          = 26;
   localparam int POS_W          = 4;
   localparam int VAL_W          = 2;
   localparam int ACC_W          = IDX_W + 1;
   localparam int MAX_POSITIONS  = 16;
   localparam int NUM_CELLS      = 17;
   localparam int DIGITS_DEFAULT = 16;

   localparam logic [VAL_W-1:0] DIG_ZERO = 2'd0;
   localparam logic [VAL_W-1:0] DIG_ONE  = 2'd1;
   localparam logic [VAL_W-1:0] DIG_TWO  = 2'd2;

   typedef logic [ACC_W-1:0] pow_table_type [NUM_CELLS];

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] rem;
      logic [IDX_W-1:0] red;
   } link_type;

   function automatic pow_table_type pow3_table();
      pow_table_type tbl;
      logic [ACC_W-1:0] p;
      p = ACC_W'(1);
      for (int i = 0; i < NUM_CELLS; i++) begin
         tbl[i] = p;
         p = ACC_W'(p * ACC_W'(3));
      end
      return tbl;
   endfunction

   localparam pow_table_type POW3 = pow3_table();

   function automatic logic [ACC_W-1:0] digit_times_pow(logic [VAL_W-1:0] d,
                                                        logic [ACC_W-1:0] p);
      logic [ACC_W-1:0] r;
      case (d)
         DIG_ONE: r = p;
         DIG_TWO: r = p << 1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/tdn_cell.sv */
// ----------------------------------------------------------------------------
// Ternary decoder cell
// Extracts one base-3 digit by comparing against a fixed power of three and
// hands the remainder to the next lower cell. The digit is held until the
// next item passes through.
// ----------------------------------------------------------------------------
module tdn_cell #(
   parameter int POSITION = 0,
   parameter bit TAP      = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdn_pkg::link_type       link_in,
   output tdn_pkg::link_type       link_out,
   output logic [tdn_pkg::VAL_W-1:0] digit
);
   import tdn_pkg::*;

   localparam logic [ACC_W-1:0] P1 = POW3[POSITION];
   localparam logic [ACC_W-1:0] P2 = P1 << 1;

   logic             valid_ff;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] red_ff, red_in;
   logic [VAL_W-1:0] digit_ff, digit_in;
   logic [ACC_W-1:0] rem_ext, sub, rem_nx;

   always_comb begin
      rem_ext = {1'b0, link_in.rem};
      if (rem_ext >= P2) begin
         digit_in = DIG_TWO;
         sub      = P2;
      end else if (rem_ext >= P1) begin
         digit_in = DIG_ONE;
         sub      = P1;
      end else begin
         digit_in = DIG_ZERO;
         sub      = '0;
      end
      rem_nx = rem_ext - sub;
      rem_in = rem_nx[IDX_W-1:0];
      red_in = TAP ? rem_nx[IDX_W-1:0] : link_in.red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= link_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (link_in.valid) begin
         rem_ff   <= rem_in;
         red_ff   <= red_in;
         digit_ff <= digit_in;
      end
   end

   assign link_out = '{valid: valid_ff, rem: rem_ff, red: red_ff};
   assign digit    = digit_ff;

endmodule

/* rtl/tdn_emitter.sv */
// ----------------------------------------------------------------------------
// Neighbor result emitter
// Takes the decoded digits and the reduced index, then walks every position
// and digit value, producing one neighbor per cycle from a running sum.
// ----------------------------------------------------------------------------
module tdn_emitter #(
   parameter int NP = tdn_pkg::MAX_POSITIONS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      dec_valid,
   input  logic [tdn_pkg::IDX_W-1:0] dec_red,
   input  logic [tdn_pkg::VAL_W-1:0] dec_digits [NP],
   output logic                      hold,
   output logic                      rsp_valid,
   output logic [tdn_pkg::IDX_W-1:0] rsp_neighbor_index,
   output logic [tdn_pkg::POS_W-1:0] rsp_digit_position,
   output logic [tdn_pkg::VAL_W-1:0] rsp_digit_value,
   output logic                      rsp_is_original,
   output logic                      rsp_last_result
);
   import tdn_pkg::*;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(NP - 1);

   logic             active_ff, active_in;
   logic             hold_ff, hold_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0] red_ff, red_in;
   logic [VAL_W-1:0] digs_ff [0:NP];
   logic [VAL_W-1:0] digs_in [0:NP];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] nbr_ff, nbr_in;
   logic [POS_W-1:0] rpos_ff, rpos_in;
   logic [VAL_W-1:0] rval_ff, rval_in;
   logic             orig_ff, orig_in;
   logic             last_ff, last_in;

   logic             last_now, free, pend, load;
   logic [POS_W:0]   pos_nx;

   always_comb begin
      last_now = active_ff && (pos_ff == POS_LAST) && (val_ff == DIG_TWO);
      free     = !active_ff || last_now;
      pend     = dec_valid || hold_ff;
      load     = pend && free;
      pos_nx   = {1'b0, pos_ff} + (POS_W+1)'(1);

      active_in = active_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      acc_in    = acc_ff;
      red_in    = red_ff;
      digs_in   = digs_ff;
      hold_in   = pend && !free;

      rsp_valid_in = active_ff;
      nbr_in       = acc_ff[IDX_W-1:0];
      rpos_in      = pos_ff;
      rval_in      = val_ff;
      orig_in      = (val_ff == digs_ff[0]);
      last_in      = last_now;

      if (active_ff) begin
         if (val_ff != DIG_TWO) begin
            val_in = val_ff + VAL_W'(1);
            acc_in = acc_ff + POW3[{1'b0, pos_ff}];
         end else begin
            pos_in = pos_nx[POS_W-1:0];
            val_in = DIG_ZERO;
            acc_in = {1'b0, red_ff} - digit_times_pow(digs_ff[1], POW3[pos_nx]);
            for (int j = 0; j < NP; j++) begin
               digs_in[j] = digs_ff[j+1];
            end
            digs_in[NP] = DIG_ZERO;
            active_in   = !last_now;
         end
      end

      if (load) begin
         active_in = 1'b1;
         pos_in    = '0;
         val_in    = DIG_ZERO;
         red_in    = dec_red;
         acc_in    = {1'b0, dec_red} - digit_times_pow(dec_digits[0], POW3[0]);
         for (int j = 0; j < NP; j++) begin
            digs_in[j] = dec_digits[j];
         end
         digs_in[NP] = DIG_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      val_ff  <= val_in;
      acc_ff  <= acc_in;
      red_ff  <= red_in;
      digs_ff <= digs_in;
      nbr_ff  <= nbr_in;
      rpos_ff <= rpos_in;
      rval_ff <= rval_in;
      orig_ff <= orig_in;
      last_ff <= last_in;
   end

   assign hold               = hold_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = nbr_ff;
   assign rsp_digit_position = rpos_ff;
   assign rsp_digit_value    = rval_ff;
   assign rsp_is_original    = orig_ff;
   assign rsp_last_result    = last_ff;

endmodule

/* rtl/ternary_digit_neighbor_generator.sv */
// An accepted item passes through the 17-cell decoder chain and, with the emitter idle,
// is loaded at once; its 3*min(DIGITS,16) results then follow on consecutive cycles.
// A new item is taken only while busy is low, once the previous one has left the
// decoder chain and been loaded by the emitter, which produces one result per cycle.
// Reset clears all valid flags; busy is low and no result is shown after reset.
// The receiver cannot stall; results leave on consecutive cycles without gaps.
// ----------------------------------------------------------------------------
// Ternary digit neighbor generator
// Decodes an index into base-3 digits through a chain of cells, then lists every
// single-digit replacement of the index modulo 3^DIGITS in its low min(DIGITS,16) digits.
// ----------------------------------------------------------------------------
module ternary_digit_neighbor_generator #(
   parameter int DIGITS = tdn_pkg::DIGITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [tdn_pkg::IDX_W-1:0] req_genome_index,
   output logic                      rsp_valid,
   output logic [tdn_pkg::IDX_W-1:0] rsp_neighbor_index,
   output logic [tdn_pkg::POS_W-1:0] rsp_digit_position,
   output logic [tdn_pkg::VAL_W-1:0] rsp_digit_value,
   output logic                      rsp_is_original,
   output logic                      rsp_last_result
);
   import tdn_pkg::*;

   localparam int NP = (DIGITS > MAX_POSITIONS) ? MAX_POSITIONS : DIGITS;

   link_type         link [0:NUM_CELLS];
   logic [VAL_W-1:0] cell_digit [NUM_CELLS];
   logic [VAL_W-1:0] dec_digits [NP];
   logic             any_valid;
   logic             hold;

   assign link[NUM_CELLS] = '{valid: start && !busy,
                              rem:   req_genome_index,
                              red:   req_genome_index};

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      tdn_cell #(
         .POSITION (k),
         .TAP      (k == DIGITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (link[k+1]),
         .link_out (link[k]),
         .digit    (cell_digit[k])
      );
   end

   for (genvar j = 0; j < NP; j++) begin : g_dig
      assign dec_digits[j] = cell_digit[j];
   end

   always_comb begin
      any_valid = 1'b0;
      for (int k = 0; k < NUM_CELLS; k++) begin
         any_valid = any_valid | link[k].valid;
      end
   end

   assign busy = any_valid || hold;

   tdn_emitter #(
      .NP (NP)
   ) u_emitter (
      .clock              (clock),
      .reset              (reset),
      .dec_valid          (link[0].valid),
      .dec_red            (link[0].red),
      .dec_digits         (dec_digits),
      .hold               (hold),
      .rsp_valid          (rsp_valid),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_digit_position (rsp_digit_position),
      .rsp_digit_value    (rsp_digit_value),
      .rsp_is_original    (rsp_is_original),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

/* rtl/tdn_checker.sv */
// ----------------------------------------------------------------------------
// Ternary digit neighbor generator checker
// Port-level assertions on transfer sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module tdn_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_valid,
   input logic [tdn_pkg::POS_W-1:0] rsp_digit_position,
   input logic [tdn_pkg::VAL_W-1:0] rsp_digit_value,
   input logic                      rsp_last_result
);
   import tdn_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after an input transfer");

   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |=> rsp_valid)
      else $error("gap inside a result run");

   a_value_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_value != DIG_TWO |=>
         rsp_digit_position == $past(rsp_digit_position) &&
         rsp_digit_value == $past(rsp_digit_value) + VAL_W'(1))
      else $error("digit value did not advance within a position");

   a_last_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |-> rsp_valid && rsp_digit_value == DIG_TWO)
      else $error("final result flag on a bad transfer");

endmodule

bind ternary_digit_neighbor_generator tdn_checker u_tdn_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ternary digit neighbor generator testbench
// Sends genome indices through the start/busy command port and rebuilds every
// single-digit base-3 replacement of each index. Each strobed result is
// checked field by field, in order, against the rebuilt list.
// ----------------------------------------------------------------------------
module testbench;

   import tdn_pkg::*;

   localparam int DIGITS      = DIGITS_DEFAULT;
   localparam int RANDOM_RUNS = 200;
   localparam int MAX_IDX     = (1 << IDX_W) - 1;

   typedef struct packed {
      logic [IDX_W-1:0] neighbor;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
      logic             original;
      logic             last;
   } neighbor_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [IDX_W-1:0] req_genome_index = '0;
   logic busy;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_neighbor_index;
   logic [POS_W-1:0] rsp_digit_position;
   logic [VAL_W-1:0] rsp_digit_value;
   logic rsp_is_original;
   logic rsp_last_result;

   logic [IDX_W-1:0] genome_queue[$];
   neighbor_type pending_neighbors[$];

   int total_genomes = 0;
   int accepted_genomes = 0;
   int wrapped_genomes = 0;
   int checked_neighbors = 0;
   int error_count = 0;
   int hold_off = 0;
   int gap = 0;
   bit drain_wait = 1'b0;
   bit drain = 1'b0;
   neighbor_type expected;

   ternary_digit_neighbor_generator #(
      .DIGITS(DIGITS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_genome_index  (req_genome_index),
      .rsp_valid         (rsp_valid),
      .rsp_neighbor_index(rsp_neighbor_index),
      .rsp_digit_position(rsp_digit_position),
      .rsp_digit_value   (rsp_digit_value),
      .rsp_is_original   (rsp_is_original),
      .rsp_last_result   (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void enumerate_neighbors(input logic [IDX_W-1:0] genome);
      longint unsigned rest;
      longint unsigned reduced;
      longint unsigned weight;
      longint unsigned cleared;
      longint unsigned weights[40];
      int unsigned digits[40];
      int n_decoded;
      int n_positions;
      neighbor_type item;
      n_decoded = (DIGITS < 1) ? 1 : ((DIGITS > 40) ? 40 : DIGITS);
      n_positions = (DIGITS < 1) ? 1 : ((DIGITS > MAX_POSITIONS) ? MAX_POSITIONS : DIGITS);
      rest = genome;
      reduced = 0;
      weight = 1;
      for (int i = 0; i < n_decoded; i++) begin
         digits[i] = int'(rest % 3);
         rest = rest / 3;
         weights[i] = weight;
         reduced += digits[i] * weight;
         weight *= 3;
      end
      if (reduced != longint'(genome)) begin
         wrapped_genomes++;
      end
      for (int i = 0; i < n_positions; i++) begin
         cleared = reduced - digits[i] * weights[i];
         for (int val = 0; val < 3; val++) begin
            item.neighbor = IDX_W'(cleared + val * weights[i]);
            item.position = POS_W'(i);
            item.value = VAL_W'(val);
            item.original = (val == digits[i]);
            item.last = (i == n_positions - 1) && (VAL_W'(val) == DIG_TWO);
            pending_neighbors.push_back(item);
         end
      end
   endfunction

   // Each two-bit field of the word is one base-3 digit, least significant first.
   function automatic logic [IDX_W-1:0] ternary_pack(input logic [31:0] digit_word);
      longint unsigned acc;
      longint unsigned weight;
      acc = 0;
      weight = 1;
      for (int i = 0; i < 16; i++) begin
         acc += longint'(digit_word[2*i +: 2] == 2'd3 ? 2'd2 : digit_word[2*i +: 2]) * weight;
         weight *= 3;
      end
      return IDX_W'(acc);
   endfunction

   function automatic logic [31:0] random_digit_word(input int bias_two);
      logic [31:0] word;
      for (int i = 0; i < 16; i++) begin
         if ($urandom_range(0, 99) < bias_two) begin
            word[2*i +: 2] = DIG_TWO;
         end else begin
            word[2*i +: 2] = 2'($urandom_range(0, 2));
         end
      end
      return word;
   endfunction

   function automatic int next_gap();
      int roll;
      if ((accepted_genomes / 32) % 3 == 1) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 90);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_genome_index <= '0;
         hold_off = 0;
         drain_wait = 1'b0;
      end else if (start && !busy) begin
         enumerate_neighbors(req_genome_index);
         accepted_genomes++;
         gap = next_gap();
         drain = (accepted_genomes % 40 == 17);
         if (gap == 0 && !drain && genome_queue.size() > 0) begin
            req_genome_index <= genome_queue.pop_front();
         end else begin
            start <= 1'b0;
            hold_off = gap;
            drain_wait = drain;
         end
      end else if (!start) begin
         if (hold_off > 0) begin
            hold_off--;
         end else if (drain_wait) begin
            if (pending_neighbors.size() == 0) begin
               drain_wait = 1'b0;
            end
         end else if (genome_queue.size() > 0) begin
            start <= 1'b1;
            req_genome_index <= genome_queue.pop_front();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_neighbors.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("Unexpected result: neighbor %0d position %0d value %0d",
                        rsp_neighbor_index, rsp_digit_position, rsp_digit_value);
            end
         end else begin
            expected = pending_neighbors.pop_front();
            checked_neighbors++;
            if (rsp_neighbor_index !== expected.neighbor
                || rsp_digit_position !== expected.position
                || rsp_digit_value !== expected.value
                || rsp_is_original !== expected.original
                || rsp_last_result !== expected.last) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("Mismatch: expected idx %0d pos %0d val %0d orig %0b last %0b",
                           expected.neighbor, expected.position, expected.value,
                           expected.original, expected.last);
                  $display("          actual   idx %0d pos %0d val %0d orig %0b last %0b",
                           rsp_neighbor_index, rsp_digit_position, rsp_digit_value,
                           rsp_is_original, rsp_last_result);
               end
            end
         end
      end
   end

   initial begin
      int roll;
      genome_queue.push_back(IDX_W'(0));
      genome_queue.push_back(IDX_W'(1));
      genome_queue.push_back(IDX_W'(2));
      genome_queue.push_back(IDX_W'(3));
      genome_queue.push_back(IDX_W'(8));
      genome_queue.push_back(ternary_pack(32'hAAAA_AAAA));
      genome_queue.push_back(ternary_pack(32'hAAAA_AAAA) - 1'b1);
      genome_queue.push_back(ternary_pack(32'hAAAA_AAAA) + 1'b1);
      genome_queue.push_back(ternary_pack(32'hAAAA_AAAA) + 2'd2);
      genome_queue.push_back(IDX_W'(MAX_IDX));
      genome_queue.push_back(IDX_W'(1) << (IDX_W - 1));
      genome_queue.push_back(ternary_pack(32'h5555_5555));
      genome_queue.push_back(ternary_pack(32'h8888_8888));
      genome_queue.push_back(ternary_pack(32'h2222_2222));
      genome_queue.push_back(ternary_pack(32'h4000_0000));
      genome_queue.push_back(ternary_pack(32'h8000_0000));
      genome_queue.push_back(ternary_pack(32'h0000_0002));
      genome_queue.push_back(IDX_W'(32'h0155_5555));
      genome_queue.push_back(IDX_W'(32'h02AA_AAAA));
      for (int i = 0; i < RANDOM_RUNS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            genome_queue.push_back(IDX_W'($urandom_range(0, MAX_IDX)));
         end else if (roll < 80) begin
            genome_queue.push_back(ternary_pack(random_digit_word(0)));
         end else if (roll < 90) begin
            genome_queue.push_back(ternary_pack(random_digit_word(80)));
         end else begin
            genome_queue.push_back(ternary_pack(32'hAAAA_AAAA)
                                   + IDX_W'($urandom_range(0, 64)));
         end
      end
      total_genomes = genome_queue.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (accepted_genomes < total_genomes) @(posedge clock);
      while (pending_neighbors.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      error_count += pending_neighbors.size();
      $display("Covered %0d genome indices (%0d reduced modulo 3^%0d), %0d neighbors checked.",
               total_genomes, wrapped_genomes, DIGITS, checked_neighbors);
      $display("Mismatches and stray or missing results: %0d.", error_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Run timed out.");
      $display("CHECK FAILED");
      $finish;
   end

endmodule
